// File: design/wms_pkg.sv
// ----------------------------------------------------------------------------
// wms_pkg - shared types and constants for the window motor sequencer
// Request/result structs, configuration block, drive and travel codes.
// ----------------------------------------------------------------------------
package wms_pkg;

	localparam int SAMPLE_BITS = 12;
	localparam int TICK_BITS   = 16;
	localparam int AIR_BITS    = 16;
	localparam int CFG_BITS    = 16;
	localparam int CFG_IDX_BITS = 3;

	// operation codes of a request
	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_OPEN  = 2'd1;
	localparam logic [1:0] OP_CLOSE = 2'd2;
	localparam logic [1:0] OP_STOP  = 2'd3;

	// motor drive codes
	localparam logic [1:0] DRV_OFF = 2'd0;
	localparam logic [1:0] DRV_FWD = 2'd1;
	localparam logic [1:0] DRV_REV = 2'd2;

	// travel codes
	localparam logic [1:0] TRV_NONE  = 2'd0;
	localparam logic [1:0] TRV_OPEN  = 2'd1;
	localparam logic [1:0] TRV_CLOSE = 2'd2;

	// action once a back-off run ends
	localparam logic [1:0] AFT_STOP   = 2'd0;
	localparam logic [1:0] AFT_WINDOW = 2'd1;
	localparam logic [1:0] AFT_HANDLE = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_LIMIT  = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_HAND_LIMIT    = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_BACKOFF_TICKS = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_PM25_LIMIT    = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_CH2O_LIMIT    = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] REG_TVOC_LIMIT    = 3'd5;
	localparam logic [CFG_IDX_BITS-1:0] REG_CO2_LIMIT     = 3'd6;

	// reset values of the configuration registers
	localparam logic [SAMPLE_BITS-1:0] RST_WINDOW_LIMIT  = 12'd1500;
	localparam logic [SAMPLE_BITS-1:0] RST_HAND_LIMIT    = 12'd900;
	localparam logic [TICK_BITS-1:0]   RST_BACKOFF_TICKS = 16'd500;
	localparam logic [AIR_BITS-1:0]    RST_PM25_LIMIT    = 16'd1000;
	localparam logic [AIR_BITS-1:0]    RST_CH2O_LIMIT    = 16'd80;
	localparam logic [AIR_BITS-1:0]    RST_TVOC_LIMIT    = 16'd600;
	localparam logic [AIR_BITS-1:0]    RST_CO2_LIMIT     = 16'd1000;

	typedef struct packed {
		logic [1:0]             op;
		logic [SAMPLE_BITS-1:0] window_current;
		logic [SAMPLE_BITS-1:0] hand_current;
		logic [AIR_BITS-1:0]    pm25;
		logic [AIR_BITS-1:0]    ch2o;
		logic [AIR_BITS-1:0]    tvoc;
		logic [AIR_BITS-1:0]    co2;
		logic                   rain;
	} req_t;

	typedef struct packed {
		logic [1:0] hand_drive;
		logic [1:0] window_drive;
		logic [1:0] motion;
		logic       window_open;
		logic       backing_off;
	} rsp_t;

	typedef struct packed {
		logic [SAMPLE_BITS-1:0] window_limit;
		logic [SAMPLE_BITS-1:0] hand_limit;
		logic [TICK_BITS-1:0]   backoff_ticks;
		logic [AIR_BITS-1:0]    pm25_limit;
		logic [AIR_BITS-1:0]    ch2o_limit;
		logic [AIR_BITS-1:0]    tvoc_limit;
		logic [AIR_BITS-1:0]    co2_limit;
	} cfg_t;

	typedef struct packed {
		logic [1:0] hand;
		logic [1:0] window;
	} drv_pair_t;

	// motor drives applied when a back-off run ends; unused code stops both
	function automatic drv_pair_t finish_drive(input logic [1:0] code);
		drv_pair_t d;
		unique case (code)
			AFT_WINDOW: begin
				d.hand   = DRV_OFF;
				d.window = DRV_FWD;
			end
			AFT_HANDLE: begin
				d.hand   = DRV_REV;
				d.window = DRV_OFF;
			end
			default: begin
				d.hand   = DRV_OFF;
				d.window = DRV_OFF;
			end
		endcase
		return d;
	endfunction

endpackage

// File: design/wms_cfg.sv
// ----------------------------------------------------------------------------
// wms_cfg - configuration register file
// Limits and back-off length, written through a plain write port.
// ----------------------------------------------------------------------------
module wms_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [wms_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [wms_pkg::CFG_BITS-1:0]     cfg_data,
	output wms_pkg::cfg_t                    cfg
);
	import wms_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.window_limit  <= RST_WINDOW_LIMIT;
			cfg_q.hand_limit    <= RST_HAND_LIMIT;
			cfg_q.backoff_ticks <= RST_BACKOFF_TICKS;
			cfg_q.pm25_limit    <= RST_PM25_LIMIT;
			cfg_q.ch2o_limit    <= RST_CH2O_LIMIT;
			cfg_q.tvoc_limit    <= RST_TVOC_LIMIT;
			cfg_q.co2_limit     <= RST_CO2_LIMIT;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WINDOW_LIMIT:  cfg_q.window_limit  <= cfg_data[SAMPLE_BITS-1:0];
				REG_HAND_LIMIT:    cfg_q.hand_limit    <= cfg_data[SAMPLE_BITS-1:0];
				REG_BACKOFF_TICKS: cfg_q.backoff_ticks <= cfg_data[TICK_BITS-1:0];
				REG_PM25_LIMIT:    cfg_q.pm25_limit    <= cfg_data[AIR_BITS-1:0];
				REG_CH2O_LIMIT:    cfg_q.ch2o_limit    <= cfg_data[AIR_BITS-1:0];
				REG_TVOC_LIMIT:    cfg_q.tvoc_limit    <= cfg_data[AIR_BITS-1:0];
				REG_CO2_LIMIT:     cfg_q.co2_limit     <= cfg_data[AIR_BITS-1:0];
				default: ;  // index beyond the list: ignored
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: design/wms_core.sv
// ----------------------------------------------------------------------------
// wms_core - sequencer state and next-state logic
// Updates the motor, travel, back-off and flag state for one request.
// ----------------------------------------------------------------------------
module wms_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          step,
	input  wms_pkg::req_t req,
	input  wms_pkg::cfg_t cfg,
	output wms_pkg::rsp_t rsp
);
	import wms_pkg::*;

	logic [1:0]           travel_q, travel_n;
	logic [1:0]           hand_q, hand_n;
	logic [1:0]           window_q, window_n;
	logic [TICK_BITS-1:0] count_q, count_n;
	logic [1:0]           after_q, after_n;
	logic                 open_q, open_n;
	logic                 rain_seen_q, rain_seen_n;

	logic      air_hit;
	logic      win_stall;
	logic      hand_stall;
	logic      ticks_zero;
	drv_pair_t fin_now;
	drv_pair_t fin_stop;
	drv_pair_t fin_window;
	drv_pair_t fin_handle;

	assign win_stall  = req.window_current > cfg.window_limit;
	assign hand_stall = req.hand_current > cfg.hand_limit;
	assign air_hit    = (req.pm25 > cfg.pm25_limit) || (req.ch2o > cfg.ch2o_limit) ||
	                    (req.tvoc > cfg.tvoc_limit) || (req.co2 > cfg.co2_limit);
	assign ticks_zero = cfg.backoff_ticks == '0;
	assign fin_now    = finish_drive(after_q);
	assign fin_stop   = finish_drive(AFT_STOP);
	assign fin_window = finish_drive(AFT_WINDOW);
	assign fin_handle = finish_drive(AFT_HANDLE);

	always_comb begin
		travel_n    = travel_q;
		hand_n      = hand_q;
		window_n    = window_q;
		count_n     = count_q;
		after_n     = after_q;
		open_n      = open_q;
		rain_seen_n = rain_seen_q;

		if (count_q != '0) begin
			// back-off running: keys dropped, ticks count down
			if (req.op == OP_TICK) begin
				count_n = count_q - 1'b1;
				if (count_q == {{(TICK_BITS-1){1'b0}}, 1'b1}) begin
					hand_n   = fin_now.hand;
					window_n = fin_now.window;
				end
			end
		end else begin
			unique case (req.op)
				OP_OPEN: begin
					open_n   = 1'b1;
					travel_n = TRV_OPEN;
					hand_n   = DRV_FWD;
				end
				OP_CLOSE: begin
					open_n   = 1'b0;
					travel_n = TRV_CLOSE;
					window_n = DRV_REV;
				end
				OP_STOP: begin
					if (travel_q == TRV_OPEN || travel_q == TRV_CLOSE) begin
						window_n = (travel_q == TRV_OPEN) ? DRV_REV : DRV_FWD;
						travel_n = TRV_NONE;
						after_n  = AFT_STOP;
						count_n  = cfg.backoff_ticks;
						if (ticks_zero) begin
							hand_n   = fin_stop.hand;
							window_n = fin_stop.window;
						end
					end else begin
						travel_n = TRV_NONE;
						hand_n   = DRV_OFF;
						window_n = DRV_OFF;
					end
				end
				default: begin
					// sample tick: first stall check that fires wins the tick
					priority if (travel_q == TRV_CLOSE && win_stall) begin
						window_n = DRV_FWD;
						after_n  = AFT_HANDLE;
						count_n  = cfg.backoff_ticks;
						if (ticks_zero) begin
							hand_n   = fin_handle.hand;
							window_n = fin_handle.window;
						end
					end else if (travel_q == TRV_CLOSE && hand_stall) begin
						travel_n = TRV_NONE;
						hand_n   = DRV_FWD;
						after_n  = AFT_STOP;
						count_n  = cfg.backoff_ticks;
						if (ticks_zero) begin
							hand_n   = fin_stop.hand;
							window_n = fin_stop.window;
						end
					end else if (travel_q == TRV_OPEN && hand_stall) begin
						hand_n  = DRV_REV;
						after_n = AFT_WINDOW;
						count_n = cfg.backoff_ticks;
						if (ticks_zero) begin
							hand_n   = fin_window.hand;
							window_n = fin_window.window;
						end
					end else if (travel_q == TRV_OPEN && win_stall) begin
						travel_n = TRV_NONE;
						window_n = DRV_REV;
						after_n  = AFT_STOP;
						count_n  = cfg.backoff_ticks;
						if (ticks_zero) begin
							hand_n   = fin_stop.hand;
							window_n = fin_stop.window;
						end
					end else if (air_hit && !open_q) begin
						open_n      = 1'b1;
						rain_seen_n = 1'b0;
						travel_n    = TRV_OPEN;
						hand_n      = DRV_FWD;
					end else if (req.rain && open_q) begin
						if (rain_seen_q) begin
							// second rainy tick in a row closes
							rain_seen_n = 1'b0;
							open_n      = 1'b0;
							travel_n    = TRV_CLOSE;
							window_n    = DRV_REV;
						end else begin
							rain_seen_n = 1'b1;
						end
					end else begin
						rain_seen_n = 1'b0;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			travel_q    <= TRV_NONE;
			hand_q      <= DRV_OFF;
			window_q    <= DRV_OFF;
			count_q     <= '0;
			after_q     <= AFT_STOP;
			open_q      <= 1'b0;
			rain_seen_q <= 1'b0;
		end else if (step) begin
			travel_q    <= travel_n;
			hand_q      <= hand_n;
			window_q    <= window_n;
			count_q     <= count_n;
			after_q     <= after_n;
			open_q      <= open_n;
			rain_seen_q <= rain_seen_n;
		end
	end

	// result is the state after this request
	assign rsp.hand_drive   = hand_n;
	assign rsp.window_drive = window_n;
	assign rsp.motion       = travel_n;
	assign rsp.window_open  = open_n;
	assign rsp.backing_off  = count_n != '0;

endmodule

// File: design/window_motor_sequencer_unit.sv
// ----------------------------------------------------------------------------
// window_motor_sequencer_unit - two-motor window sequencer, top level
// Input register, sequencer state update, result register.
// ----------------------------------------------------------------------------
//
//  channel   handshake               payload     direction
//  -------   ---------------------   ---------   ---------
//  request   req_valid / req_ready   req_data    into block
//  result    rsp_valid / rsp_ready   rsp_data    out of block
//  config    cfg_we (no wait)        cfg_index,  into block
//                                    cfg_data
//
// One request per cycle sustained while results are taken: a request sits in the input
// register, the state update and result are computed from it and land in the
// result register.
// Every request gives exactly one result (motor drives, travel, flags).
// Reset clears all sequencer state and loads the default limits; no sweep.
// A stalled result holds the result register; the input register still takes
// a new request while it is empty, then waits with it.
//
module window_motor_sequencer_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             req_valid,
	output logic                             req_ready,
	input  wms_pkg::req_t                    req_data,
	output logic                             rsp_valid,
	input  logic                             rsp_ready,
	output wms_pkg::rsp_t                    rsp_data,
	input  logic                             cfg_we,
	input  logic [wms_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [wms_pkg::CFG_BITS-1:0]     cfg_data
);
	import wms_pkg::*;

	cfg_t cfg;
	req_t req_s1;
	logic valid_s1;
	rsp_t rsp_next;
	rsp_t rsp_q;
	logic rsp_valid_q;
	logic advance;

	// request in stage 1 moves on when the result register is free or draining
	assign advance   = valid_s1 && (!rsp_valid_q || rsp_ready);
	assign req_ready = !valid_s1 || advance;

	wms_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_s1 <= req_data;
		end
	end

	// state commits only when the request's result is taken into rsp_q
	wms_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.req    (req_s1),
		.cfg    (cfg),
		.rsp    (rsp_next)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q <= rsp_next;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

endmodule
